// File: hdl/stu_pkg.sv
// Shared types and constants for the semaphore table unit.
package stu_pkg;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned IDX_W    = 8;
    localparam int unsigned PID_W    = 15;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_INIT    = 3'd0;
    localparam logic [OP_W-1:0] OP_WAIT    = 3'd1;
    localparam logic [OP_W-1:0] OP_SIGNAL  = 3'd2;
    localparam logic [OP_W-1:0] OP_DESTROY = 3'd3;
    localparam logic [OP_W-1:0] OP_EXIT    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BLOCKED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_QFULL     = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] sem_index;
        logic [PID_W-1:0] caller_pid;
        logic [CNT_W-1:0] init_value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                woken_valid;
        logic [PID_W-1:0]    woken_pid;
        logic                woken_aborted;
        logic                last;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_POP_RD,
        S_POP_WAIT,
        S_POP_OUT,
        S_SCAN,
        S_FREE,
        S_DONE
    } t_state;

endpackage

// File: hdl/stu_ram.sv
// Generic single-port-write, registered-read RAM.
module stu_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hdl/semaphore_table_unit_core.sv
// Top level of the semaphore table unit: sequencer, slot tables and wait queues.
//
// Usage: one request word enters on i_req (valid/ready). The block answers
// with zero or more wake words (woken_valid=1) followed by one final word
// (last=1) carrying the caller status on o_rsp (valid/ready).
// One request is handled at a time; o_req_ready is low until the last word
// has been handed to the output register.
// Init, wait and signal without a waiter answer with the final word alone.
// Each released waiter takes a read on the shared queue read port and can
// be held by an output stall. Owner exit walks the NUM_SEMS slots, one per
// cycle, pausing to free each owned slot and pop its waiters; it stops with
// busy status when its wakes would exceed WAIT_DEPTH.
// The single waiter memory read port serializes the wakes.
// Reset clears all in-use bits and queue pointers at once; no clearing pass
// is needed. When the receiver stalls, the output register holds its word and
// the sequencer waits; no word is lost or repeated.
module semaphore_table_unit_core #(
    parameter int unsigned NUM_SEMS   = 32,
    parameter int unsigned WAIT_DEPTH = 16,
    parameter int unsigned PID_BITS   = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  stu_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output stu_pkg::t_rsp o_rsp
);

    localparam int unsigned SW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int unsigned QW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int unsigned LW  = $clog2(WAIT_DEPTH + 1);
    localparam int unsigned KW  = $clog2(WAIT_DEPTH + 1);
    localparam int unsigned MD  = NUM_SEMS * WAIT_DEPTH;
    localparam int unsigned MW  = (MD > 1) ? $clog2(MD) : 1;
    localparam int unsigned CW  = $clog2(NUM_SEMS + 1);

    // slot tables (NUM_SEMS entries per slot field)
    logic                      r_in_use [NUM_SEMS];
    logic [PID_BITS-1:0]       r_owner  [NUM_SEMS];
    logic [stu_pkg::CNT_W-1:0] r_count  [NUM_SEMS];
    logic [QW-1:0]             r_head   [NUM_SEMS];
    logic [QW-1:0]             r_tail   [NUM_SEMS];
    logic [LW-1:0]             r_len    [NUM_SEMS];

    stu_pkg::t_state r_state, n_state;
    logic [stu_pkg::OP_W-1:0]  r_op;
    logic [PID_BITS-1:0]       r_pid;
    logic [stu_pkg::CNT_W-1:0] r_ival;
    logic                      r_idx_ok;
    logic [SW-1:0]             r_sel;
    logic [CW-1:0]             r_scan;
    logic [KW-1:0]             r_k;
    logic                      r_abort;
    logic [stu_pkg::STATUS_W-1:0] r_status;

    // current slot snapshot
    logic                      r_s_use;
    logic [PID_BITS-1:0]       r_s_own;
    logic [stu_pkg::CNT_W-1:0] r_s_cnt;
    logic [QW-1:0]             r_s_head;
    logic [QW-1:0]             r_s_tail;
    logic [LW-1:0]             r_s_len;

    logic                r_rsp_valid;
    stu_pkg::t_rsp       r_out;
    logic                out_free;
    logic                out_load;

    logic                mem_we;
    logic [MW-1:0]       mem_waddr, mem_raddr;
    logic [PID_BITS-1:0] mem_rdata;

    assign out_free    = !r_rsp_valid || i_rsp_ready;
    assign out_load    = ((r_state == stu_pkg::S_POP_OUT) || (r_state == stu_pkg::S_DONE))
                         && out_free;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_out;
    assign o_req_ready = (r_state == stu_pkg::S_IDLE);

    logic accept;
    assign accept = i_req_valid && o_req_ready;

    logic [MW-1:0] sel_base;
    assign sel_base = MW'(r_sel * WAIT_DEPTH);

    assign mem_raddr = sel_base + MW'(r_s_head);
    assign mem_waddr = sel_base + MW'(r_s_tail);
    assign mem_we    = (r_state == stu_pkg::S_EXEC) && (r_op == stu_pkg::OP_WAIT)
                       && r_s_use && r_idx_ok && (r_s_cnt == '0)
                       && (r_s_len < LW'(WAIT_DEPTH));

    stu_ram #(.WIDTH(PID_BITS), .DEPTH(MD)) u_waiters (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(r_pid),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    function automatic logic [QW-1:0] adv(input logic [QW-1:0] p);
        logic [QW-1:0] q;
        q = (32'(p) + 1 >= WAIT_DEPTH) ? '0 : QW'(32'(p) + 1);
        return q;
    endfunction

    logic live;
    assign live = r_idx_ok && r_s_use;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            stu_pkg::S_IDLE:     if (accept) n_state = stu_pkg::S_LOOK;
            stu_pkg::S_LOOK:     n_state = (r_op == stu_pkg::OP_EXIT) ? stu_pkg::S_SCAN
                                                                      : stu_pkg::S_EXEC;
            stu_pkg::S_EXEC: begin
                if (live && (r_op == stu_pkg::OP_SIGNAL) && (r_s_len != '0)) begin
                    n_state = stu_pkg::S_POP_RD;
                end else if (live && (r_op == stu_pkg::OP_DESTROY)
                             && (r_s_own == r_pid)) begin
                    n_state = (r_s_len != '0) ? stu_pkg::S_POP_RD : stu_pkg::S_FREE;
                end else begin
                    n_state = stu_pkg::S_DONE;
                end
            end
            stu_pkg::S_POP_RD:   n_state = stu_pkg::S_POP_WAIT;
            stu_pkg::S_POP_WAIT: n_state = stu_pkg::S_POP_OUT;
            stu_pkg::S_POP_OUT: begin
                if (out_free) begin
                    if (!r_abort) n_state = stu_pkg::S_DONE;
                    else if (r_s_len == LW'(1)) n_state = stu_pkg::S_FREE;
                    else n_state = stu_pkg::S_POP_RD;
                end
            end
            stu_pkg::S_FREE:     n_state = (r_op == stu_pkg::OP_EXIT) ? stu_pkg::S_SCAN
                                                                      : stu_pkg::S_DONE;
            stu_pkg::S_SCAN: begin
                if (r_scan >= CW'(NUM_SEMS)) n_state = stu_pkg::S_DONE;
                else if (r_in_use[r_scan[SW-1:0]] && r_owner[r_scan[SW-1:0]] == r_pid) begin
                    if (KW'(32'(r_k) + 32'(r_len[r_scan[SW-1:0]])) > KW'(WAIT_DEPTH)
                        || 32'(r_k) + 32'(r_len[r_scan[SW-1:0]]) > WAIT_DEPTH)
                        n_state = stu_pkg::S_DONE;
                    else if (r_len[r_scan[SW-1:0]] != '0) n_state = stu_pkg::S_POP_RD;
                    else n_state = stu_pkg::S_FREE;
                end
            end
            stu_pkg::S_DONE:     if (out_free) n_state = stu_pkg::S_IDLE;
            default:             n_state = stu_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    logic scan_hit;
    logic [SW-1:0] scan_s;
    assign scan_s   = r_scan[SW-1:0];
    assign scan_hit = (r_scan < CW'(NUM_SEMS)) && r_in_use[scan_s]
                      && (r_owner[scan_s] == r_pid);

    // datapath and tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
            r_k         <= '0;
            for (int i = 0; i < NUM_SEMS; i++) begin
                r_in_use[i] <= 1'b0;
                r_head[i]   <= '0;
                r_tail[i]   <= '0;
                r_len[i]    <= '0;
            end
        end else begin
            if (out_load) r_rsp_valid <= 1'b1;
            else if (r_rsp_valid && i_rsp_ready) r_rsp_valid <= 1'b0;
            case (r_state)
                stu_pkg::S_IDLE: begin
                    if (accept) begin
                        r_op     <= i_req.op;
                        r_pid    <= PID_BITS'(i_req.caller_pid);
                        r_ival   <= i_req.init_value;
                        r_idx_ok <= 32'(i_req.sem_index) < NUM_SEMS;
                        r_sel    <= SW'(i_req.sem_index);
                        r_scan   <= '0;
                        r_k      <= '0;
                        r_status <= stu_pkg::ST_OK;
                        r_abort  <= 1'b0;
                    end
                end
                stu_pkg::S_LOOK: begin
                    r_s_use  <= r_in_use[r_sel];
                    r_s_own  <= r_owner[r_sel];
                    r_s_cnt  <= r_count[r_sel];
                    r_s_head <= r_head[r_sel];
                    r_s_tail <= r_tail[r_sel];
                    r_s_len  <= r_len[r_sel];
                end
                stu_pkg::S_EXEC: begin
                    case (r_op)
                        stu_pkg::OP_INIT: begin
                            if (!r_idx_ok) r_status <= stu_pkg::ST_INVALID;
                            else if (r_s_use) r_status <= stu_pkg::ST_BUSY;
                            else begin
                                r_in_use[r_sel] <= 1'b1;
                                r_owner[r_sel]  <= r_pid;
                                r_count[r_sel]  <= r_ival;
                                r_head[r_sel]   <= '0;
                                r_tail[r_sel]   <= '0;
                                r_len[r_sel]    <= '0;
                            end
                        end
                        stu_pkg::OP_WAIT: begin
                            if (!live) r_status <= stu_pkg::ST_INVALID;
                            else if (r_s_cnt != '0) r_count[r_sel] <= r_s_cnt - 1'b1;
                            else if (r_s_len >= LW'(WAIT_DEPTH))
                                r_status <= stu_pkg::ST_QFULL;
                            else begin
                                r_tail[r_sel] <= adv(r_s_tail);
                                r_len[r_sel]  <= r_s_len + 1'b1;
                                r_status      <= stu_pkg::ST_BLOCKED;
                            end
                        end
                        stu_pkg::OP_SIGNAL: begin
                            if (!live) r_status <= stu_pkg::ST_INVALID;
                            else if (r_s_len == '0 && r_s_cnt != '1)
                                r_count[r_sel] <= r_s_cnt + 1'b1;
                        end
                        stu_pkg::OP_DESTROY: begin
                            if (!live) r_status <= stu_pkg::ST_INVALID;
                            else if (r_s_own != r_pid) r_status <= stu_pkg::ST_NOT_OWNER;
                            else r_abort <= 1'b1;
                        end
                        default: r_status <= stu_pkg::ST_INVALID;
                    endcase
                end
                stu_pkg::S_SCAN: begin
                    r_sel    <= scan_s;
                    r_s_head <= r_head[scan_s];
                    r_s_len  <= r_len[scan_s];
                    r_abort  <= 1'b1;
                    if (scan_hit && (32'(r_k) + 32'(r_len[scan_s]) > WAIT_DEPTH)) begin
                        r_status <= stu_pkg::ST_BUSY;
                    end
                    r_scan <= r_scan + 1'b1;
                end
                stu_pkg::S_POP_OUT: begin
                    if (out_free) begin
                        r_out.status        <= stu_pkg::ST_OK;
                        r_out.woken_valid   <= 1'b1;
                        r_out.woken_pid     <= stu_pkg::PID_W'(mem_rdata);
                        r_out.woken_aborted <= r_abort;
                        r_out.last          <= 1'b0;
                        r_s_head            <= adv(r_s_head);
                        r_s_len             <= r_s_len - 1'b1;
                        r_head[r_sel]       <= adv(r_s_head);
                        r_len[r_sel]        <= r_s_len - 1'b1;
                        r_k                 <= r_k + 1'b1;
                    end
                end
                stu_pkg::S_FREE: begin
                    r_in_use[r_sel] <= 1'b0;
                    r_head[r_sel]   <= '0;
                    r_tail[r_sel]   <= '0;
                end
                stu_pkg::S_DONE: begin
                    if (out_free) begin
                        r_out.status        <= r_status;
                        r_out.woken_valid   <= 1'b0;
                        r_out.woken_pid     <= '0;
                        r_out.woken_aborted <= 1'b0;
                        r_out.last          <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // a wake word is never the last word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.woken_valid |-> !o_rsp.last)
        else $error("wake word flagged last");

    // request ready only while the sequencer is idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready |-> (r_state == stu_pkg::S_IDLE))
        else $error("ready outside idle");

    // wake count per call stays within queue depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_k) <= WAIT_DEPTH)
        else $error("wake count overrun");

    // a final word loaded in the done state is presented as valid and last in the cycle after
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stu_pkg::S_DONE) && out_free |=> o_rsp_valid && o_rsp.last)
        else $error("final word missing");

endmodule

// File: tb/sv/semaphore_table_unit_core_tb.sv
// Testbench for the semaphore table unit: request words in, wake and status words checked.
`timescale 1ns / 1ps

module semaphore_table_unit_core_tb;

    localparam int unsigned N_SEMS    = 32;
    localparam int unsigned Q_DEPTH   = 16;
    localparam longint      MAX_CYCLES = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    stu_pkg::t_req i_req = '0;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    stu_pkg::t_rsp o_rsp;

    always #2 i_clk = ~i_clk;

    semaphore_table_unit_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    // shadow of the semaphore bank
    bit                        sh_used  [N_SEMS];
    logic [stu_pkg::PID_W-1:0] sh_owner [N_SEMS];
    logic [stu_pkg::CNT_W-1:0] sh_count [N_SEMS];
    logic [stu_pkg::PID_W-1:0] sh_waiters[N_SEMS][$];

    stu_pkg::t_rsp rsp_expected[$];
    int     n_errors = 0;
    longint cycle_cnt = 0;
    bit     src_idle_en = 1'b1;
    bit     sink_idle_en = 1'b1;
    int     sink_hold = 0;
    bit     long_stall = 1'b0;
    event   stall_start;

    function automatic stu_pkg::t_rsp mk_rsp(logic [stu_pkg::STATUS_W-1:0] st, bit wv,
                                             logic [stu_pkg::PID_W-1:0] p, bit ab, bit lst);
        stu_pkg::t_rsp r;
        r.status = st;
        r.woken_valid = wv;
        r.woken_pid = p;
        r.woken_aborted = ab;
        r.last = lst;
        return r;
    endfunction

    function automatic void release_sem(int s);
        while (sh_waiters[s].size() > 0)
            rsp_expected.push_back(mk_rsp(stu_pkg::ST_OK, 1'b1, sh_waiters[s].pop_front(),
                                          1'b1, 1'b0));
        sh_used[s] = 1'b0;
    endfunction

    function automatic void predict_call(stu_pkg::t_req rq);
        logic [stu_pkg::STATUS_W-1:0] st;
        bit ok_idx;
        bit live;
        int ix;
        int wakes;
        st = stu_pkg::ST_OK;
        ix = rq.sem_index;
        ok_idx = ix < N_SEMS;
        live = ok_idx && sh_used[ix];
        case (rq.op)
            stu_pkg::OP_INIT: begin
                if (!ok_idx) st = stu_pkg::ST_INVALID;
                else if (sh_used[ix]) st = stu_pkg::ST_BUSY;
                else begin
                    sh_used[ix] = 1'b1;
                    sh_owner[ix] = rq.caller_pid;
                    sh_count[ix] = rq.init_value;
                    sh_waiters[ix].delete();
                end
            end
            stu_pkg::OP_WAIT: begin
                if (!live) st = stu_pkg::ST_INVALID;
                else if (sh_count[ix] > 0) sh_count[ix]--;
                else if (sh_waiters[ix].size() >= Q_DEPTH) st = stu_pkg::ST_QFULL;
                else begin
                    sh_waiters[ix].push_back(rq.caller_pid);
                    st = stu_pkg::ST_BLOCKED;
                end
            end
            stu_pkg::OP_SIGNAL: begin
                if (!live) st = stu_pkg::ST_INVALID;
                else if (sh_waiters[ix].size() > 0)
                    rsp_expected.push_back(mk_rsp(stu_pkg::ST_OK, 1'b1,
                                                  sh_waiters[ix].pop_front(), 1'b0, 1'b0));
                else if (sh_count[ix] != 16'hFFFF) sh_count[ix]++;
            end
            stu_pkg::OP_DESTROY: begin
                if (!live) st = stu_pkg::ST_INVALID;
                else if (sh_owner[ix] != rq.caller_pid) st = stu_pkg::ST_NOT_OWNER;
                else release_sem(ix);
            end
            stu_pkg::OP_EXIT: begin
                wakes = 0;
                for (int s = 0; s < N_SEMS; s++) begin
                    if (sh_used[s] && sh_owner[s] == rq.caller_pid) begin
                        if (wakes + sh_waiters[s].size() > Q_DEPTH) begin
                            st = stu_pkg::ST_BUSY;
                            break;
                        end
                        wakes += sh_waiters[s].size();
                        release_sem(s);
                    end
                end
            end
            default: st = stu_pkg::ST_INVALID;
        endcase
        rsp_expected.push_back(mk_rsp(st, 1'b0, '0, 1'b0, 1'b1));
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLES) begin
            $display("semaphore_table_unit_core: mismatch");
            $finish;
        end
    end

    // response checker
    always @(posedge i_clk) begin
        stu_pkg::t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (rsp_expected.size() == 0) begin
                $error("unexpected word %p", o_rsp);
                n_errors++;
            end else begin
                want = rsp_expected.pop_front();
                if (o_rsp.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, o_rsp.status);
                    n_errors++;
                end
                if (o_rsp.woken_valid !== want.woken_valid) begin
                    $error("woken_valid exp %0d got %0d", want.woken_valid, o_rsp.woken_valid);
                    n_errors++;
                end
                if (o_rsp.woken_pid !== want.woken_pid) begin
                    $error("woken_pid exp %0d got %0d", want.woken_pid, o_rsp.woken_pid);
                    n_errors++;
                end
                if (o_rsp.woken_aborted !== want.woken_aborted) begin
                    $error("woken_aborted exp %0d got %0d", want.woken_aborted,
                           o_rsp.woken_aborted);
                    n_errors++;
                end
                if (o_rsp.last !== want.last) begin
                    $error("last exp %0d got %0d", want.last, o_rsp.last);
                    n_errors++;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always begin
        @(stall_start);
        long_stall <= 1'b1;
        repeat (300) @(posedge i_clk);
        long_stall <= 1'b0;
    end

    // receiver: random stall bursts, plus the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
        end else if (long_stall) begin
            i_rsp_ready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            i_rsp_ready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            sink_hold <= $urandom_range(1, 15) - 1;
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= 1'b1;
        end
    end

    // valid stays up after a word is taken unless a gap follows or the caller drains
    task automatic send_call(logic [stu_pkg::OP_W-1:0] op, logic [stu_pkg::IDX_W-1:0] ix,
                             logic [stu_pkg::PID_W-1:0] p, logic [stu_pkg::CNT_W-1:0] v);
        stu_pkg::t_req rq;
        int gap;
        rq.op = op;
        rq.sem_index = ix;
        rq.caller_pid = p;
        rq.init_value = v;
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= rq;
        do @(posedge i_clk); while (!o_req_ready);
        predict_call(rq);
    endtask

    task automatic drain_all();
        i_req_valid <= 1'b0;
        while (rsp_expected.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_call(stu_pkg::OP_INIT, 8'd255, 15'h7FFF, 16'hFFFF);  // bad index
        send_call(stu_pkg::OP_WAIT, 8'd40, 15'd1, 16'd0);
        send_call(3'd5, 8'd0, 15'd1, 16'd0);                      // undefined ops
        send_call(3'd7, 8'd0, 15'd1, 16'd0);
        send_call(stu_pkg::OP_WAIT, 8'd0, 15'd1, 16'd0);          // free slot
        send_call(stu_pkg::OP_INIT, 8'd0, 15'd0, 16'hFFFE);
        send_call(stu_pkg::OP_INIT, 8'd0, 15'd3, 16'd0);          // busy
        send_call(stu_pkg::OP_SIGNAL, 8'd0, 15'd9, 16'd0);
        send_call(stu_pkg::OP_SIGNAL, 8'd0, 15'd9, 16'd0);        // saturates
        send_call(stu_pkg::OP_WAIT, 8'd0, 15'd2, 16'd0);
        send_call(stu_pkg::OP_INIT, 8'd31, 15'h7FFF, 16'd0);
        for (int i = 0; i < 17; i++)                              // last one hits queue full
            send_call(stu_pkg::OP_WAIT, 8'd31, 15'(i * 1927 + 5), 16'd0);
        send_call(stu_pkg::OP_SIGNAL, 8'd31, 15'd1, 16'd0);
        send_call(stu_pkg::OP_DESTROY, 8'd31, 15'd1, 16'd0);      // not owner
        send_call(stu_pkg::OP_DESTROY, 8'd31, 15'h7FFF, 16'd0);
        send_call(stu_pkg::OP_DESTROY, 8'd0, 15'd0, 16'd0);
        drain_all();
    endtask

    // owner exit with more waiters than one call can release
    task automatic test_owner_exit();
        for (int s = 1; s <= 3; s++) begin
            send_call(stu_pkg::OP_INIT, stu_pkg::IDX_W'(s), 15'd77, 16'd0);
            for (int w = 0; w < 7; w++)
                send_call(stu_pkg::OP_WAIT, stu_pkg::IDX_W'(s), 15'($urandom), 16'd0);
        end
        send_call(stu_pkg::OP_EXIT, 8'($urandom), 15'd77, 16'($urandom));
        send_call(stu_pkg::OP_EXIT, 8'd0, 15'd77, 16'd0);
        send_call(stu_pkg::OP_EXIT, 8'd0, 15'd77, 16'd0);
        drain_all();
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        send_call(stu_pkg::OP_INIT, 8'd5, 15'd10, 16'd0);
        for (int w = 0; w < 8; w++) send_call(stu_pkg::OP_WAIT, 8'd5, 15'(100 + w), 16'd0);
        drain_all();
        @(posedge i_clk);
        -> stall_start;
        for (int w = 0; w < 8; w++) send_call(stu_pkg::OP_SIGNAL, 8'd5, 15'd1, 16'd0);
        send_call(stu_pkg::OP_DESTROY, 8'd5, 15'd10, 16'd0);
        drain_all();
    endtask

    task automatic test_random(int n_items);
        logic [stu_pkg::OP_W-1:0] op;
        logic [stu_pkg::IDX_W-1:0] ix;
        logic [stu_pkg::PID_W-1:0] p;
        int r;
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items - 40) begin
                src_idle_en = 1'b0;
                sink_idle_en = 1'b0;
            end
            r = $urandom_range(0, 99);
            if (r < 4) ix = 8'($urandom);
            else ix = stu_pkg::IDX_W'($urandom_range(0, 5));
            p = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 3));
            r = $urandom_range(0, 99);
            if (r < 15) op = stu_pkg::OP_INIT;
            else if (r < 50) op = stu_pkg::OP_WAIT;
            else if (r < 78) op = stu_pkg::OP_SIGNAL;
            else if (r < 88) op = stu_pkg::OP_DESTROY;
            else if (r < 96) op = stu_pkg::OP_EXIT;
            else op = stu_pkg::OP_W'($urandom_range(5, 7));
            send_call(op, ix, p, ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                 16'($urandom_range(0, 2)));
        end
        drain_all();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_owner_exit();
        test_backpressure();
        test_random(150);
        if (n_errors == 0 && rsp_expected.size() == 0) begin
            $display("semaphore_table_unit_core: match");
        end else begin
            $display("semaphore_table_unit_core: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/stu_pkg.sv
hdl/stu_ram.sv
hdl/semaphore_table_unit_core.sv
tb/sv/semaphore_table_unit_core_tb.sv
